// ===== hw/rtl/etb_pkg.sv =====
package etb_pkg;

    localparam int MAX_TIMERS_DEF = 24;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] CFG_TIMERS    = 2'd0;
    localparam logic [1:0] CFG_ROUTE_CAP = 2'd1;
    localparam logic [1:0] CFG_CAP       = 2'd2;
    localparam logic [1:0] CFG_MSI       = 2'd3;

    localparam logic [9:0] A_CAP_LO = 10'h000;
    localparam logic [9:0] A_CAP_HI = 10'h004;
    localparam logic [9:0] A_GEN    = 10'h010;
    localparam logic [9:0] A_GEN_HI = 10'h014;
    localparam logic [9:0] A_STATUS = 10'h020;
    localparam logic [9:0] A_CNT_LO = 10'h0f0;
    localparam logic [9:0] A_CNT_HI = 10'h0f4;

    localparam logic [4:0] T_CFG      = 5'h00;
    localparam logic [4:0] T_CFG_HI   = 5'h04;
    localparam logic [4:0] T_CMP      = 5'h08;
    localparam logic [4:0] T_CMP_HI   = 5'h0c;
    localparam logic [4:0] T_ROUTE    = 5'h10;
    localparam logic [4:0] T_ROUTE_HI = 5'h14;

    localparam logic [4:0] TIMER_BASE = 5'd8;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_OFF = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    localparam logic K_ACCESS = 1'b0;
    localparam logic K_IRQ    = 1'b1;

    localparam int MODE_LEVEL  = 1;
    localparam int MODE_EN     = 2;
    localparam int MODE_PER    = 3;
    localparam int MODE_SETVAL = 6;
    localparam int MODE_B32    = 8;
    localparam int MODE_FSB_EN = 14;

    localparam logic [15:0] MODE_WMASK   = 16'h7f4e;
    localparam logic [15:0] MODE_RESET   = 16'h0030;
    localparam logic [15:0] MODE_FSB_CAP = 16'h8000;

    localparam logic [4:0] ROUTE_LEGACY0 = 5'd0;
    localparam logic [4:0] ROUTE_LEGACY1 = 5'd8;

    typedef struct packed {
        logic        kind;
        logic [63:0] data;
        logic [1:0]  status;
        logic [4:0]  line;
        logic        level;
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_TWRITE,
        S_TW1,
        S_SCAN,
        S_NEXT,
        S_FIRE0,
        S_DIV,
        S_ADV0,
        S_ADV1,
        S_DIST,
        S_WRAP,
        S_DLINE,
        S_DRV,
        S_DRV2,
        S_RESP,
        S_END
    } t_state;

    typedef enum logic [2:0] {
        C_TICK,
        C_GEN_ON,
        C_GEN_OFF,
        C_CLR,
        C_ONE
    } t_ctx;

endpackage

// ===== hw/rtl/etb_out.sv =====
module etb_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  etb_pkg::t_res i_word,
    input  logic          i_end,
    output logic          o_push_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output etb_pkg::t_res o_word,
    output logic          o_last
);

    logic          r_out_v;
    logic          r_pend_v;
    logic          r_last;
    etb_pkg::t_res r_out;
    etb_pkg::t_res r_pend;
    logic          w_free;

    assign w_free       = !r_out_v || i_ready;
    assign o_push_ready = w_free;
    assign o_valid      = r_out_v;
    assign o_word       = r_out;
    assign o_last       = r_last;

    // one word held back so the last flag is known when it leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end
            if (w_free && i_push) begin
                if (r_pend_v) begin
                    r_out   <= r_pend;
                    r_last  <= 1'b0;
                    r_out_v <= 1'b1;
                end
                r_pend   <= i_word;
                r_pend_v <= 1'b1;
            end else if (w_free && i_end && r_pend_v) begin
                r_out    <= r_pend;
                r_last   <= 1'b1;
                r_out_v  <= 1'b1;
                r_pend_v <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/event_timer_block.sv =====
// Event timer with a 64-bit main counter and up to MAX_TIMERS comparators.
// Input channel (i_valid/o_ready): one word per access or tick; opcode 0
// advances the counter when enabled, 1 reads a register, 2 writes one.
// Output channel (o_valid/i_ready): interrupt line changes first, then the
// access response; o_last marks the final word of each input word.
// The block takes one input word at a time. A tick scans the timers one
// per cycle while none fires; each firing timer holds the scan while its
// deadline is handled, and a periodic timer also computes a bit-serial
// remainder through the shared 64-bit adder. Enable and status-clear
// writes scan all timers in use the same way.
// Reset (synchronous, active low) restores the control and timer registers
// to their reset values at once; the block is ready in the next cycle.
// When the receiver stalls, one word waits in the output register and one
// is held back; the sequencer then waits on its next output word.
// The configuration port may be written while the block is idle.
module event_timer_block #(
    parameter int MAX_TIMERS = etb_pkg::MAX_TIMERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [9:0]  i_address,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [63:0] o_read_data,
    output logic [1:0]  o_status,
    output logic [4:0]  o_irq_line,
    output logic        o_irq_level,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int IW = $clog2(MAX_TIMERS);
    localparam int CW = $clog2(MAX_TIMERS + 1);

    logic [4:0]  r_tiu;
    logic [31:0] r_route_cap;
    logic [63:0] r_cap_word;
    logic        r_msi;

    etb_pkg::t_state r_state;
    etb_pkg::t_state n_state;
    etb_pkg::t_state r_ret;
    etb_pkg::t_ctx   r_ctx;

    logic [1:0]  r_op;
    logic [9:0]  r_addr;
    logic [31:0] r_data;
    logic [1:0]  r_st;
    logic [63:0] r_rdata;
    logic [CW-1:0] r_idx;
    logic        r_set;
    logic        r_arming;
    logic [63:0] r_d;
    logic [63:0] r_e;
    logic [63:0] r_rem;
    logic [5:0]  r_bitcnt;

    logic [63:0] r_cnt;
    logic [1:0]  r_gen;
    logic [MAX_TIMERS-1:0] r_irq_status;
    logic [15:0] r_mode  [MAX_TIMERS];
    logic [63:0] r_cmp   [MAX_TIMERS];
    logic [63:0] r_per   [MAX_TIMERS];
    logic [63:0] r_route [MAX_TIMERS];
    logic [63:0] r_dl    [MAX_TIMERS];
    logic [MAX_TIMERS-1:0] r_armed;
    logic [MAX_TIMERS-1:0] r_wrap;

    logic [4:0]    w_tiu_clamp;
    logic [CW-1:0] w_n;
    logic [4:0]    w_id;
    logic          w_in_range;
    logic          w_is_timer;
    logic [4:0]    w_off;
    logic [IW-1:0] w_ti;
    logic [15:0]   w_mode;
    logic [63:0]   w_cmp;
    logic          w_b32;
    logic          w_per;
    logic [63:0]   w_step;
    logic          w_gen_en;
    logic          w_rising;
    logic          w_falling;
    logic [4:0]    w_route;
    logic          w_hi_route;
    logic [MAX_TIMERS-1:0] w_hit;
    logic          w_fire_hit;
    logic          w_idx_end;
    logic          w_per_go;
    logic          w_e_neg;

    logic [63:0] w_alu_a;
    logic [63:0] w_alu_b;
    logic        w_alu_sub;
    logic [64:0] w_sum;
    logic [63:0] w_dist;
    logic [32:0] w_to_wrap;
    logic        w_trial_ok;

    logic [63:0] w_rd_val;
    logic [1:0]  w_rd_st;
    logic [63:0] w_cfg_word;

    logic          w_deassert;
    logic          w_pulse;
    logic          w_push;
    logic          w_end;
    etb_pkg::t_res w_word;
    etb_pkg::t_res w_out_word;
    logic          w_push_ready;
    logic          w_adv;

    assign o_ready = (r_state == etb_pkg::S_IDLE);

    always_comb begin
        if (r_tiu < 5'd3) begin
            w_tiu_clamp = 5'd3;
        end else if (r_tiu > 5'(MAX_TIMERS)) begin
            w_tiu_clamp = 5'(MAX_TIMERS);
        end else begin
            w_tiu_clamp = r_tiu;
        end
    end

    assign w_n        = w_tiu_clamp[CW-1:0];
    assign w_id       = r_addr[9:5] - etb_pkg::TIMER_BASE;
    assign w_in_range = w_id < 5'(w_n);
    assign w_is_timer = (r_addr[9:8] != 2'b00);
    assign w_off      = r_addr[4:0];
    assign w_ti       = r_idx[IW-1:0];
    assign w_mode     = r_mode[w_ti];
    assign w_cmp      = r_cmp[w_ti];
    assign w_b32      = w_mode[etb_pkg::MODE_B32];
    assign w_per      = w_mode[etb_pkg::MODE_PER];
    assign w_step     = w_b32 ? {33'b0, r_per[w_ti][30:0]} : r_per[w_ti];
    assign w_gen_en   = r_gen[0];
    assign w_rising   = !w_gen_en && r_data[0];
    assign w_falling  = w_gen_en && !r_data[0];
    assign w_hit      = r_data[MAX_TIMERS-1:0] & r_irq_status;
    assign w_fire_hit = r_armed[w_ti] && (r_dl[w_ti] == r_cnt);
    assign w_idx_end  = (r_idx >= w_n);
    assign w_per_go   = w_per && (w_step != 64'd0);
    assign w_e_neg    = w_b32 ? w_sum[31] : w_sum[63];

    always_comb begin
        if (r_gen[1] && (r_idx == CW'(0))) begin
            w_route = etb_pkg::ROUTE_LEGACY0;
        end else if (r_gen[1] && (r_idx == CW'(1))) begin
            w_route = etb_pkg::ROUTE_LEGACY1;
        end else begin
            w_route = w_mode[13:9];
        end
    end

    assign w_hi_route = w_route[4];

    // shared 64-bit adder
    always_comb begin
        w_alu_a   = r_cnt;
        w_alu_b   = 64'd0;
        w_alu_sub = 1'b0;
        case (r_state)
            etb_pkg::S_START: begin
                w_alu_b = 64'd1;
            end
            etb_pkg::S_DIST: begin
                w_alu_a   = w_cmp;
                w_alu_b   = r_cnt;
                w_alu_sub = 1'b1;
            end
            etb_pkg::S_DLINE: begin
                w_alu_b = r_d;
            end
            etb_pkg::S_FIRE0: begin
                w_alu_b   = w_cmp;
                w_alu_sub = 1'b1;
            end
            etb_pkg::S_DIV: begin
                w_alu_a   = {r_rem[62:0], r_e[63]};
                w_alu_b   = w_step;
                w_alu_sub = 1'b1;
            end
            etb_pkg::S_ADV0: begin
                w_alu_b   = r_rem;
                w_alu_sub = 1'b1;
            end
            etb_pkg::S_ADV1: begin
                w_alu_a = r_e;
                w_alu_b = w_step;
            end
            default: begin
            end
        endcase
    end

    assign w_sum = {1'b0, w_alu_a} + {1'b0, w_alu_b ^ {64{w_alu_sub}}} + 65'(w_alu_sub);
    assign w_trial_ok = r_rem[63] || w_sum[64];
    assign w_to_wrap  = 33'h1_0000_0000 - {1'b0, r_cnt[31:0]};

    always_comb begin
        if (w_b32) begin
            w_dist = (w_sum[31:0] != 32'd0 && !w_sum[31]) ? {32'b0, w_sum[31:0]} : 64'd1;
        end else begin
            w_dist = (w_sum[63:0] != 64'd0 && !w_sum[63]) ? w_sum[63:0] : 64'd1;
        end
    end

    assign w_cfg_word = {r_route_cap, 16'b0, w_mode | (r_msi ? etb_pkg::MODE_FSB_CAP : 16'h0)};

    always_comb begin
        w_rd_val = 64'd0;
        w_rd_st  = etb_pkg::ST_OK;
        if (w_is_timer) begin
            case (w_off)
                etb_pkg::T_CFG:      w_rd_val = w_cfg_word;
                etb_pkg::T_CFG_HI:   w_rd_val = {32'b0, w_cfg_word[63:32]};
                etb_pkg::T_CMP:      w_rd_val = w_cmp;
                etb_pkg::T_CMP_HI:   w_rd_val = {32'b0, w_cmp[63:32]};
                etb_pkg::T_ROUTE:    w_rd_val = r_route[w_ti];
                etb_pkg::T_ROUTE_HI: w_rd_val = {32'b0, r_route[w_ti][63:32]};
                default:             w_rd_st  = etb_pkg::ST_BAD_OFF;
            endcase
        end else begin
            case (r_addr)
                etb_pkg::A_CAP_LO: w_rd_val = r_cap_word;
                etb_pkg::A_CAP_HI: w_rd_val = {32'b0, r_cap_word[63:32]};
                etb_pkg::A_GEN:    w_rd_val = {62'b0, r_gen};
                etb_pkg::A_STATUS: w_rd_val = 64'(r_irq_status);
                etb_pkg::A_CNT_LO: w_rd_val = r_cnt;
                etb_pkg::A_CNT_HI: w_rd_val = {32'b0, r_cnt[63:32]};
                default:           w_rd_st  = etb_pkg::ST_BAD_OFF;
            endcase
        end
    end

    assign w_deassert = !r_set || !w_mode[etb_pkg::MODE_EN] || !w_gen_en;
    assign w_pulse    = !w_deassert && !w_mode[etb_pkg::MODE_FSB_EN]
                        && !w_mode[etb_pkg::MODE_LEVEL];

    // output word requests
    always_comb begin
        w_push = 1'b0;
        w_end  = 1'b0;
        w_word = '{kind: etb_pkg::K_IRQ, data: 64'd0, status: etb_pkg::ST_OK,
                   line: w_route, level: 1'b0};
        case (r_state)
            etb_pkg::S_DRV: begin
                w_push = !w_mode[etb_pkg::MODE_FSB_EN];
                if (w_deassert) begin
                    w_word.level = w_hi_route;
                end else if (w_mode[etb_pkg::MODE_LEVEL]) begin
                    w_word.level = !w_hi_route;
                end else begin
                    w_word.level = 1'b1;
                end
            end
            etb_pkg::S_DRV2: begin
                w_push = 1'b1;
            end
            etb_pkg::S_RESP: begin
                w_push = 1'b1;
                w_word = '{kind: etb_pkg::K_ACCESS, data: r_rdata, status: r_st,
                           line: 5'd0, level: 1'b0};
            end
            etb_pkg::S_END: begin
                w_end = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign w_adv = w_push_ready || !(w_push || w_end);

    always_comb begin
        n_state = r_state;
        case (r_state)
            etb_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = etb_pkg::S_START;
                end
            end
            etb_pkg::S_START: begin
                case (r_op)
                    etb_pkg::OP_TICK: begin
                        n_state = w_gen_en ? etb_pkg::S_SCAN : etb_pkg::S_END;
                    end
                    etb_pkg::OP_READ: begin
                        n_state = (w_is_timer && !w_in_range) ? etb_pkg::S_RESP
                                                              : etb_pkg::S_READ;
                    end
                    etb_pkg::OP_WRITE: begin
                        if (w_is_timer) begin
                            n_state = w_in_range ? etb_pkg::S_TWRITE : etb_pkg::S_RESP;
                        end else begin
                            case (r_addr)
                                etb_pkg::A_GEN: begin
                                    n_state = (w_rising || w_falling) ? etb_pkg::S_SCAN
                                                                      : etb_pkg::S_RESP;
                                end
                                etb_pkg::A_STATUS: n_state = etb_pkg::S_SCAN;
                                default:           n_state = etb_pkg::S_RESP;
                            endcase
                        end
                    end
                    default: n_state = etb_pkg::S_END;
                endcase
            end
            etb_pkg::S_READ: n_state = etb_pkg::S_RESP;
            etb_pkg::S_TWRITE: begin
                case (w_off)
                    etb_pkg::T_CFG: begin
                        n_state = (!w_mode[etb_pkg::MODE_FSB_EN] && r_data[etb_pkg::MODE_FSB_EN])
                                  ? etb_pkg::S_DRV : etb_pkg::S_TW1;
                    end
                    etb_pkg::T_CMP, etb_pkg::T_CMP_HI: begin
                        n_state = w_gen_en ? etb_pkg::S_DIST : etb_pkg::S_NEXT;
                    end
                    default: n_state = etb_pkg::S_NEXT;
                endcase
            end
            etb_pkg::S_TW1: begin
                if (!w_mode[etb_pkg::MODE_EN] && r_data[etb_pkg::MODE_EN] && w_gen_en) begin
                    n_state = etb_pkg::S_DIST;
                end else if (w_mode[etb_pkg::MODE_EN] && !r_data[etb_pkg::MODE_EN]) begin
                    n_state = etb_pkg::S_DRV;
                end else begin
                    n_state = etb_pkg::S_NEXT;
                end
            end
            etb_pkg::S_SCAN: begin
                if (w_idx_end) begin
                    n_state = (r_ctx == etb_pkg::C_TICK) ? etb_pkg::S_END : etb_pkg::S_RESP;
                end else begin
                    case (r_ctx)
                        etb_pkg::C_TICK: begin
                            if (w_fire_hit) n_state = etb_pkg::S_FIRE0;
                        end
                        etb_pkg::C_GEN_ON: begin
                            if (w_cmp != '1) n_state = etb_pkg::S_DIST;
                        end
                        etb_pkg::C_GEN_OFF: n_state = etb_pkg::S_DRV;
                        etb_pkg::C_CLR: begin
                            if (w_hit[w_ti]) n_state = etb_pkg::S_DRV;
                        end
                        default: n_state = etb_pkg::S_RESP;
                    endcase
                end
            end
            etb_pkg::S_NEXT: begin
                n_state = (r_ctx == etb_pkg::C_ONE) ? etb_pkg::S_RESP : etb_pkg::S_SCAN;
            end
            etb_pkg::S_FIRE0: begin
                if (w_per_go) begin
                    n_state = w_e_neg ? etb_pkg::S_DIST : etb_pkg::S_DIV;
                end else if (w_b32 && !w_per && r_wrap[w_ti]) begin
                    n_state = etb_pkg::S_DIST;
                end else begin
                    n_state = etb_pkg::S_DRV;
                end
            end
            etb_pkg::S_DIV: begin
                if (r_bitcnt == 6'd63) n_state = etb_pkg::S_ADV0;
            end
            etb_pkg::S_ADV0: n_state = etb_pkg::S_ADV1;
            etb_pkg::S_ADV1: n_state = etb_pkg::S_DIST;
            etb_pkg::S_DIST: begin
                n_state = (r_arming && w_b32 && !w_per) ? etb_pkg::S_WRAP : etb_pkg::S_DLINE;
            end
            etb_pkg::S_WRAP: n_state = etb_pkg::S_DLINE;
            etb_pkg::S_DLINE: begin
                n_state = r_arming ? etb_pkg::S_NEXT : etb_pkg::S_DRV;
            end
            etb_pkg::S_DRV: begin
                if (w_adv) n_state = w_pulse ? etb_pkg::S_DRV2 : r_ret;
            end
            etb_pkg::S_DRV2: begin
                if (w_adv) n_state = r_ret;
            end
            etb_pkg::S_RESP: begin
                if (w_adv) n_state = etb_pkg::S_END;
            end
            etb_pkg::S_END: begin
                if (w_adv) n_state = etb_pkg::S_IDLE;
            end
            default: n_state = etb_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiu        <= 5'd3;
            r_route_cap  <= 32'd0;
            r_cap_word   <= 64'd0;
            r_msi        <= 1'b0;
            r_state      <= etb_pkg::S_IDLE;
            r_ret        <= etb_pkg::S_NEXT;
            r_ctx        <= etb_pkg::C_ONE;
            r_set        <= 1'b0;
            r_arming     <= 1'b0;
            r_idx        <= '0;
            r_bitcnt     <= 6'd0;
            r_cnt        <= 64'd0;
            r_gen        <= 2'd0;
            r_irq_status <= '0;
            r_armed      <= '0;
            r_wrap       <= '0;
            for (int i = 0; i < MAX_TIMERS; i++) begin
                r_mode[i]  <= etb_pkg::MODE_RESET;
                r_cmp[i]   <= '1;
                r_per[i]   <= 64'd0;
                r_route[i] <= 64'd0;
                r_dl[i]    <= 64'd0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    etb_pkg::CFG_TIMERS:    r_tiu       <= i_cfg_data[4:0];
                    etb_pkg::CFG_ROUTE_CAP: r_route_cap <= i_cfg_data[31:0];
                    etb_pkg::CFG_CAP:       r_cap_word  <= i_cfg_data;
                    etb_pkg::CFG_MSI:       r_msi       <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            r_state <= n_state;

            case (r_state)
                etb_pkg::S_IDLE: begin
                    if (i_valid) begin
                        r_op   <= i_opcode;
                        r_addr <= i_address;
                        r_data <= i_write_data;
                    end
                end
                etb_pkg::S_START: begin
                    r_st    <= etb_pkg::ST_OK;
                    r_rdata <= 64'd0;
                    r_idx   <= '0;
                    r_ctx   <= etb_pkg::C_ONE;
                    if (r_op == etb_pkg::OP_TICK) begin
                        r_ctx <= etb_pkg::C_TICK;
                        if (w_gen_en) r_cnt <= w_sum[63:0];
                    end else if (w_is_timer) begin
                        if (!w_in_range) r_st <= etb_pkg::ST_RANGE;
                        else r_idx <= CW'(w_id);
                    end else if (r_op == etb_pkg::OP_WRITE) begin
                        case (r_addr)
                            etb_pkg::A_CAP_LO, etb_pkg::A_GEN_HI: begin
                            end
                            etb_pkg::A_GEN: begin
                                r_gen <= r_data[1:0];
                                if (w_rising) r_ctx <= etb_pkg::C_GEN_ON;
                                if (w_falling) begin
                                    r_ctx   <= etb_pkg::C_GEN_OFF;
                                    r_armed <= '0;
                                end
                            end
                            etb_pkg::A_STATUS: r_ctx <= etb_pkg::C_CLR;
                            etb_pkg::A_CNT_LO: begin
                                if (!w_gen_en) r_cnt[31:0] <= r_data;
                            end
                            etb_pkg::A_CNT_HI: begin
                                if (!w_gen_en) r_cnt[63:32] <= r_data;
                            end
                            default: r_st <= etb_pkg::ST_BAD_OFF;
                        endcase
                    end
                end
                etb_pkg::S_READ: begin
                    r_st    <= w_rd_st;
                    r_rdata <= (w_rd_st == etb_pkg::ST_OK) ? w_rd_val : 64'd0;
                end
                etb_pkg::S_TWRITE: begin
                    r_set    <= 1'b0;
                    r_arming <= 1'b1;
                    r_ret    <= etb_pkg::S_TW1;
                    case (w_off)
                        etb_pkg::T_CFG, etb_pkg::T_CFG_HI: begin
                        end
                        etb_pkg::T_CMP: begin
                            if (!w_per || w_mode[etb_pkg::MODE_SETVAL])
                                r_cmp[w_ti][31:0] <= r_data;
                            if (w_per)
                                r_per[w_ti][31:0] <= w_b32 ? {1'b0, r_data[30:0]} : r_data;
                            r_mode[w_ti][etb_pkg::MODE_SETVAL] <= 1'b0;
                        end
                        etb_pkg::T_CMP_HI: begin
                            if (!w_per || w_mode[etb_pkg::MODE_SETVAL])
                                r_cmp[w_ti][63:32] <= r_data;
                            else
                                r_per[w_ti][63:32] <= {1'b0, r_data[30:0]};
                            r_mode[w_ti][etb_pkg::MODE_SETVAL] <= 1'b0;
                        end
                        etb_pkg::T_ROUTE:    r_route[w_ti][31:0]  <= r_data;
                        etb_pkg::T_ROUTE_HI: r_route[w_ti][63:32] <= r_data;
                        default:             r_st <= etb_pkg::ST_BAD_OFF;
                    endcase
                end
                etb_pkg::S_TW1: begin
                    r_set    <= 1'b0;
                    r_arming <= 1'b1;
                    r_ret    <= etb_pkg::S_NEXT;
                    r_mode[w_ti] <= (r_data[15:0] & etb_pkg::MODE_WMASK)
                                    | (w_mode & ~etb_pkg::MODE_WMASK);
                    if (r_data[etb_pkg::MODE_B32]) begin
                        r_cmp[w_ti][63:32] <= 32'd0;
                        r_per[w_ti][63:32] <= 32'd0;
                    end
                    if (w_mode[etb_pkg::MODE_EN] && !r_data[etb_pkg::MODE_EN])
                        r_armed[w_ti] <= 1'b0;
                end
                etb_pkg::S_SCAN: begin
                    r_set    <= 1'b0;
                    r_arming <= 1'b1;
                    r_ret    <= etb_pkg::S_NEXT;
                    if (n_state == etb_pkg::S_SCAN) r_idx <= r_idx + CW'(1);
                end
                etb_pkg::S_NEXT: begin
                    if (r_ctx != etb_pkg::C_ONE) r_idx <= r_idx + CW'(1);
                end
                etb_pkg::S_FIRE0: begin
                    r_set    <= 1'b1;
                    r_arming <= 1'b0;
                    r_ret    <= etb_pkg::S_NEXT;
                    r_e      <= w_b32 ? {32'b0, w_sum[31:0]} : w_sum[63:0];
                    r_rem    <= 64'd0;
                    r_bitcnt <= 6'd0;
                    if (!w_per_go) begin
                        if (w_b32 && !w_per && r_wrap[w_ti]) r_wrap[w_ti] <= 1'b0;
                        else r_armed[w_ti] <= 1'b0;
                    end
                end
                etb_pkg::S_DIV: begin
                    r_e      <= {r_e[62:0], 1'b0};
                    r_rem    <= w_trial_ok ? w_sum[63:0] : {r_rem[62:0], r_e[63]};
                    r_bitcnt <= r_bitcnt + 6'd1;
                end
                etb_pkg::S_ADV0: begin
                    r_e <= w_sum[63:0];
                end
                etb_pkg::S_ADV1: begin
                    r_cmp[w_ti] <= w_b32 ? {32'b0, w_sum[31:0]} : w_sum[63:0];
                end
                etb_pkg::S_DIST: begin
                    r_d <= w_dist;
                    if (r_arming) r_wrap[w_ti] <= 1'b0;
                end
                etb_pkg::S_WRAP: begin
                    if ({31'b0, w_to_wrap} < r_d) begin
                        r_d          <= {31'b0, w_to_wrap};
                        r_wrap[w_ti] <= 1'b1;
                    end
                end
                etb_pkg::S_DLINE: begin
                    r_dl[w_ti] <= w_sum[63:0];
                    if (r_arming) r_armed[w_ti] <= 1'b1;
                end
                etb_pkg::S_DRV: begin
                    if (w_adv) begin
                        if (w_deassert) begin
                            r_irq_status[w_ti] <= 1'b0;
                        end else if (!w_mode[etb_pkg::MODE_FSB_EN]) begin
                            r_irq_status[w_ti] <= w_mode[etb_pkg::MODE_LEVEL];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    etb_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_word       (w_word),
        .i_end        (w_end),
        .o_push_ready (w_push_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_word       (w_out_word),
        .o_last       (o_last)
    );

    assign o_kind      = w_out_word.kind;
    assign o_read_data = w_out_word.data;
    assign o_status    = w_out_word.status;
    assign o_irq_line  = w_out_word.line;
    assign o_irq_level = w_out_word.level;

endmodule
